// ===== hw/rtl/adampu_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update unit: shared package
// Store geometry, fixed-point constants and the status type of the
// iterative arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package adampu_pkg;

  // Store geometry
  localparam int BasisCount  = 256;
  localparam int OutputCount = 256;
  localparam int StoreDepth  = 3 * BasisCount + OutputCount;
  localparam int AddrW       = $clog2(StoreDepth);

  // Field widths
  localparam int IdxW   = 10;
  localparam int ParamW = 32;
  localparam int VW     = 48;
  localparam int LrW    = 24;
  localparam int TdataW = 48;
  localparam int TuserW = 2;

  // Shared multiplier: signed 33 x 33
  localparam int MulW  = 33;
  localparam int ProdW = 2 * MulW;

  // Divider: 64-bit dividend, 40-bit divisor, one quotient bit per cycle
  localparam int DivNumW = 64;
  localparam int DivDenW = 40;
  localparam int DivCntW = $clog2(DivNumW + 1);

  // Square root: 64-bit radicand, one root bit per cycle
  localparam int SqrtRadW  = 64;
  localparam int SqrtRootW = SqrtRadW / 2;
  localparam int SqrtCntW  = $clog2(SqrtRootW + 1);

  // Q2.30 constants
  localparam logic [31:0] OneQ30   = 32'd1073741824;
  localparam logic [31:0] Beta1Q30 = 32'd966367642;
  localparam logic [31:0] Beta2Q30 = 32'd1072668082;
  localparam logic [31:0] OmB1Q30  = OneQ30 - Beta1Q30;
  localparam logic [31:0] OmB2Q30  = OneQ30 - Beta2Q30;

  localparam logic [LrW-1:0] LrReset = 24'd16777;

  // Action codes (tuser bit 0)
  localparam logic ActLoad = 1'b0;
  localparam logic ActGrad = 1'b1;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adampu_div.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update unit: iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module adampu_div import adampu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic [DivNumW-1:0] quo_o,
  output unit_stat_t         stat_o
);

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = DivDenW'(trial - {1'b0, den_q});
      quo_d = {quo_q[DivNumW-2:0], 1'b1};
    end else begin
      rem_d = trial[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-2:0], 1'b0};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== hw/rtl/adampu_sqrt.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update unit: iterative square root
// Digit-by-digit integer square root, floor result, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module adampu_sqrt import adampu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SqrtRadW-1:0]  rad_i,
  output logic [SqrtRootW-1:0] root_o,
  output unit_stat_t           stat_o
);

  logic [SqrtRadW-1:0]    rad_q;
  logic [SqrtRootW+1:0]   rem_q, rem_d;
  logic [SqrtRootW-1:0]   root_q, root_d;
  logic [SqrtCntW-1:0]    cnt_q;
  logic                   busy_q, done_q;
  logic [SqrtRootW+3:0]   part, trial;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    part  = {rem_q, rad_q[SqrtRadW-1 -: 2]};
    trial = {2'b00, root_q, 2'b01};
    if (part >= trial) begin
      rem_d  = (SqrtRootW+2)'(part - trial);
      root_d = {root_q[SqrtRootW-2:0], 1'b1};
    end else begin
      rem_d  = part[SqrtRootW+1:0];
      root_d = {root_q[SqrtRootW-2:0], 1'b0};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SqrtCntW'(SqrtRootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SqrtCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqrtRadW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== hw/rtl/adam_parameter_update_unit.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update unit: top level
// Parameter and moment stores, sequencer, shared multiplier, divider and
// square root unit.
// ----------------------------------------------------------------------------
// Load request: through S_READ to S_OUT, where the result is registered, then S_IDLE.
// Gradient request: the step powers are updated first when new step is set; three
//   divisions and two square roots then run in turn on the shared units.
// One request at a time; a stalled result holds the sequencer until it drains.
// After reset a clearing pass over every store address zeroes both moment stores;
//   no request is taken meanwhile, configuration writes are.
`default_nettype none

module adam_parameter_update_unit import adampu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_wr_en_i,
  input  logic [LrW-1:0]    cfg_wr_data_i,   // learning_rate
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,    // element_index[9:0], value[41:10]
  input  logic [TuserW-1:0] s_axis_tuser,    // action[0], new_step[1]
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata     // element_out[9:0], param_value[41:10]
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_POW1, S_POW2, S_POW3, S_READ,
    S_M1, S_M2, S_M3, S_G1, S_V1, S_V2, S_V3, S_V4,
    S_DIV1, S_SQ1, S_SQ2, S_DIV2, S_P1, S_P2, S_DIV3, S_OUT
  } state_e;

  function automatic logic signed [ParamW-1:0] sat32(input logic signed [ProdW-1:0] x);
    if (x > $signed(ProdW'(64'sd2147483647)))       sat32 = 32'sh7fffffff;
    else if (x < -$signed(ProdW'(64'sd2147483648))) sat32 = 32'sh80000000;
    else                                            sat32 = x[ParamW-1:0];
  endfunction

  state_e state_q, state_d;

  // Control registers
  logic [AddrW-1:0]  clr_cnt_q;
  logic [31:0]       b1p_q, b2p_q, step_cnt_q;
  logic [LrW-1:0]    lr_q;
  logic              out_vld_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [ParamW-1:0] out_val_q;

  // Request registers and datapath
  logic [IdxW-1:0]          idx_q;
  logic signed [ParamW-1:0] val_q;
  logic                     act_q, in_range_q;
  logic signed [ProdW-1:0]  prod_q, acc_q;
  logic signed [ParamW-1:0] m_q;
  logic                     m_neg_q;
  logic [46:0]              gsq_q;
  logic [55:0]              hi_q, lo_q;
  logic [VW-1:0]            v_q;
  logic [35:0]              mhat_q;
  logic [31:0]              sv_q;
  logic [DivDenW-1:0]       denom_q;
  logic [47:0]              pl_q;
  logic [ParamW-1:0]        res_q;

  // Stores
  logic [ParamW-1:0] prm_mem [StoreDepth];
  logic [ParamW-1:0] m_mem   [StoreDepth];
  logic [VW-1:0]     v_mem   [StoreDepth];
  logic [ParamW-1:0] prm_rd_q, m_rd_q;
  logic [VW-1:0]     v_rd_q;

  logic              accept, in_range;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic              div_start, sq_start;
  logic [DivNumW-1:0] div_num, div_quo;
  logic [DivDenW-1:0] div_den;
  logic [SqrtRadW-1:0] sq_rad;
  logic [SqrtRootW-1:0] sq_root;
  unit_stat_t        div_stat, sq_stat;

  logic signed [ProdW-1:0]  m_acc, p_diff, step_s;
  logic signed [ParamW-1:0] m_new, p_new;
  logic [62:0]              gsq_full;
  logic [55:0]              lo_sum;
  logic [56:0]              v_sum;
  logic [31:0]              m_abs, g_abs, c1, c2, sc2;
  logic [59:0]              lr_num;
  logic                     prm_we, mv_clr, m_we, v_we, out_free;
  logic [AddrW-1:0]         mv_addr;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_range = {1'b0, s_axis_tdata[IdxW-1:0]} < (IdxW+1)'(StoreDepth);
  assign out_free = !out_vld_q || m_axis_tready;

  // Arithmetic around the shared units
  always_comb begin
    m_acc    = acc_q + prod_q + ProdW'(64'sd536870912);
    m_new    = sat32(m_acc >>> 30);
    gsq_full = prod_q[62:0] + 63'd32768;
    lo_sum   = lo_q + prod_q[55:0] + 56'd536870912;
    v_sum    = {1'b0, hi_q} + 57'(lo_sum[55:24]);
    m_abs    = m_q[ParamW-1] ? 32'(-m_q) : 32'(m_q);
    g_abs    = val_q[ParamW-1] ? 32'(-val_q) : 32'(val_q);
    c1       = OneQ30 - ((b1p_q > OneQ30) ? OneQ30 : b1p_q);
    if (c1 == '0) c1 = OneQ30;
    c2       = OneQ30 - ((b2p_q > OneQ30) ? OneQ30 : b2p_q);
    if (c2 == '0) c2 = OneQ30;
    sc2      = (sq_root == '0) ? 32'd1 : sq_root;
    lr_num   = 60'(pl_q) + {prod_q[35:0], 24'd0};
    step_s   = m_neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
    p_diff   = ProdW'($signed(prm_rd_q)) - step_s;
    p_new    = sat32(p_diff);
  end

  // Sequencer next state and unit strobes
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    sq_rad    = '0;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == AddrW'(StoreDepth - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser[0] == ActGrad && s_axis_tuser[1]) state_d = S_POW1;
          else                                               state_d = S_READ;
        end
      end
      S_POW1: begin
        mul_a   = $signed({1'b0, b1p_q});
        mul_b   = $signed({1'b0, Beta1Q30});
        state_d = S_POW2;
      end
      S_POW2: begin
        mul_a   = $signed({1'b0, b2p_q});
        mul_b   = $signed({1'b0, Beta2Q30});
        state_d = S_POW3;
      end
      S_POW3: state_d = S_READ;
      S_READ: state_d = (act_q == ActGrad && in_range_q) ? S_M1 : S_OUT;
      S_M1: begin
        mul_a   = MulW'($signed(m_rd_q));
        mul_b   = $signed({1'b0, Beta1Q30});
        state_d = S_M2;
      end
      S_M2: begin
        mul_a   = MulW'(val_q);
        mul_b   = $signed({1'b0, OmB1Q30});
        state_d = S_M3;
      end
      S_M3: begin
        mul_a   = $signed({1'b0, g_abs});
        mul_b   = $signed({1'b0, g_abs});
        state_d = S_G1;
      end
      S_G1: begin
        mul_a   = $signed(MulW'(v_rd_q[47:24]));
        mul_b   = $signed({1'b0, Beta2Q30});
        state_d = S_V1;
      end
      S_V1: begin
        mul_a   = $signed(MulW'(gsq_q[46:24]));
        mul_b   = $signed({1'b0, OmB2Q30});
        state_d = S_V2;
      end
      S_V2: begin
        mul_a   = $signed(MulW'(v_rd_q[23:0]));
        mul_b   = $signed({1'b0, Beta2Q30});
        state_d = S_V3;
      end
      S_V3: begin
        mul_a   = $signed(MulW'(gsq_q[23:0]));
        mul_b   = $signed({1'b0, OmB2Q30});
        state_d = S_V4;
      end
      S_V4: begin
        // m_hat = |m| * 2^30 / c1, rounded
        div_start = 1'b1;
        div_num   = DivNumW'({m_abs, 30'd0}) + DivNumW'(c1 >> 1);
        div_den   = DivDenW'(c1);
        state_d   = S_DIV1;
      end
      S_DIV1: begin
        if (div_stat.done) begin
          sq_start = 1'b1;
          sq_rad   = {v_q, 16'd0};
          state_d  = S_SQ1;
        end
      end
      S_SQ1: begin
        if (sq_stat.done) begin
          sq_start = 1'b1;
          sq_rad   = SqrtRadW'({c2, 30'd0});
          state_d  = S_SQ2;
        end
      end
      S_SQ2: begin
        if (sq_stat.done) begin
          // sqrt(v_hat) = sqrt(v) * 2^30 / sqrt(c2), rounded
          div_start = 1'b1;
          div_num   = DivNumW'({sv_q, 30'd0}) + DivNumW'(sc2 >> 1);
          div_den   = DivDenW'(sc2);
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        mul_a = $signed(MulW'(lr_q));
        mul_b = $signed(MulW'(mhat_q[23:0]));
        if (div_stat.done) state_d = S_P1;
      end
      S_P1: begin
        mul_a   = $signed(MulW'(lr_q));
        mul_b   = $signed(MulW'(mhat_q[35:24]));
        state_d = S_P2;
      end
      S_P2: begin
        // step magnitude = lr * |m_hat| / denom, rounded
        div_start = 1'b1;
        div_num   = DivNumW'(lr_num) + DivNumW'(denom_q >> 1);
        div_den   = denom_q;
        state_d   = S_DIV3;
      end
      S_DIV3: if (div_stat.done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State, step powers, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      b1p_q      <= OneQ30;
      b2p_q      <= OneQ30;
      step_cnt_q <= '0;
      lr_q       <= LrReset;
      out_vld_q  <= 1'b0;
      out_idx_q  <= '0;
      out_val_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_wr_en_i) lr_q <= cfg_wr_data_i;
      if (state_q == S_POW1 && step_cnt_q != '1) step_cnt_q <= step_cnt_q + 1'b1;
      if (state_q == S_POW2) b1p_q <= prod_q[61:30];
      if (state_q == S_POW3) b2p_q <= prod_q[61:30];
      if (state_q == S_OUT && out_free) begin
        out_vld_q <= 1'b1;
        out_idx_q <= idx_q;
        out_val_q <= res_q;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      idx_q      <= s_axis_tdata[IdxW-1:0];
      val_q      <= $signed(s_axis_tdata[IdxW +: ParamW]);
      act_q      <= s_axis_tuser[0];
      in_range_q <= in_range;
    end
    case (state_q)
      S_READ: begin
        if (act_q == ActLoad && in_range_q) res_q <= val_q;
        else                                res_q <= '0;
      end
      S_M2: acc_q <= prod_q;
      S_M3: begin
        m_q     <= m_new;
        m_neg_q <= m_new[ParamW-1];
      end
      S_G1: gsq_q <= gsq_full[62:16];
      S_V1: hi_q  <= prod_q[55:0];
      S_V2: hi_q  <= hi_q + prod_q[55:0];
      S_V3: lo_q  <= prod_q[55:0];
      S_V4: v_q   <= v_sum[53:6];
      S_DIV1: if (div_stat.done) mhat_q <= div_quo[35:0];
      S_SQ1:  if (sq_stat.done) sv_q <= sq_root;
      S_DIV2: if (div_stat.done) denom_q <= div_quo[DivDenW-1:0] + 1'b1;
      S_P1:   pl_q <= prod_q[47:0];
      S_DIV3: if (div_stat.done) res_q <= p_new;
      default: ;
    endcase
  end

  // Store write controls
  assign prm_we  = (state_q == S_READ && act_q == ActLoad && in_range_q)
                || (state_q == S_DIV3 && div_stat.done);
  assign mv_clr  = (state_q == S_CLEAR);
  assign m_we    = mv_clr || state_q == S_M3;
  assign v_we    = mv_clr || state_q == S_V4;
  assign mv_addr = mv_clr ? clr_cnt_q : idx_q[AddrW-1:0];

  // Parameter store
  always_ff @(posedge clk_i) begin
    if (prm_we) prm_mem[idx_q[AddrW-1:0]] <= (state_q == S_READ) ? val_q : p_new;
    prm_rd_q <= prm_mem[idx_q[AddrW-1:0]];
  end

  // First moment store
  always_ff @(posedge clk_i) begin
    if (m_we) m_mem[mv_addr] <= mv_clr ? '0 : m_new;
    m_rd_q <= m_mem[idx_q[AddrW-1:0]];
  end

  // Second moment store
  always_ff @(posedge clk_i) begin
    if (v_we) v_mem[mv_addr] <= mv_clr ? '0 : v_sum[53:6];
    v_rd_q <= v_mem[idx_q[AddrW-1:0]];
  end

  adampu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  adampu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .root_o  (sq_root),
    .stat_o  (sq_stat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(TdataW - IdxW - ParamW)'(0), out_val_q, out_idx_q};

  // Checks
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy && !sq_stat.busy)
    else $error("request taken while an arithmetic unit is busy");

  a_div_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted mid-operation");

  a_step_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> step_cnt_q >= $past(step_cnt_q))
    else $error("step count went backwards");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_OUT))
    else $error("result registered outside the output state");

endmodule

`default_nettype wire

// ===== tb/adam_parameter_update_checker.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update unit: result checker
// Watches the configuration port and both streams, keeps its own copy of the
// parameter and moment stores, predicts each result and compares it.
// ----------------------------------------------------------------------------
module adam_parameter_update_checker import adampu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [LrW-1:0]    cfg_wr_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [TdataW-1:0] s_tdata_i,     // element_index[9:0], value[41:10]
  input  logic [TuserW-1:0] s_tuser_i,     // action[0], new_step[1]
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [TdataW-1:0] m_tdata_i,     // element_out[9:0], param_value[41:10]
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IdxW-1:0]   elem;
    logic [ParamW-1:0] param;
  } param_result_t;

  // Predicted stores and optimiser state
  logic signed [31:0] param_mem [StoreDepth];
  logic signed [31:0] mom1_mem [StoreDepth];
  longint unsigned    mom2_mem [StoreDepth];
  logic [31:0]        step_cnt;
  logic [31:0]        b1_pow;
  logic [31:0]        b2_pow;
  logic [LrW-1:0]     lr;

  param_result_t expected_params [$];
  int                fails;
  int                pend;

  assign fail_count_o = fails;
  assign pending_o    = pend;

  // Signed quotient, rounded half away from zero
  function automatic longint rnd_div(longint n, longint unsigned d);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? -n : n;
    q   = (mag + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Applies one request to the predicted state, returns the new parameter
  function automatic logic [31:0] adam_update(logic act, logic [IdxW-1:0] idx,
                                              logic signed [31:0] val, logic ns);
    longint          g, m, acc, mhat, stp;
    longint unsigned gmag, gsq, v, c1, c2, sv, sc2, den;
    logic [127:0]    vsum;
    if (act == ActLoad) begin
      param_mem[idx] = val;
      return val;
    end
    if (ns) begin
      if (step_cnt != 32'hffffffff) step_cnt = step_cnt + 1;
      b1_pow = 32'((64'(b1_pow) * 64'(Beta1Q30)) >> 30);
      b2_pow = 32'((64'(b2_pow) * 64'(Beta2Q30)) >> 30);
    end
    g    = val;
    gmag = (g < 0) ? -g : g;
    gsq  = (gmag * gmag + (64'd1 << 15)) >> 16;
    // first moment, rounded half up
    acc  = longint'(Beta1Q30) * longint'(mom1_mem[idx]) + longint'(OmB1Q30) * g;
    m    = (acc + (64'sd1 <<< 29)) >>> 30;
    mom1_mem[idx] = clamp32(m);
    m    = mom1_mem[idx];
    // second moment in Q16.32
    vsum = 128'(mom2_mem[idx]) * 128'(Beta2Q30) + 128'(gsq) * 128'(OmB2Q30)
         + (128'd1 << 29);
    v    = 64'(vsum >> 30) & 64'hffff_ffff_ffff;
    mom2_mem[idx] = v;
    // bias correction, skipped while the power is still one
    c1 = 64'(OneQ30) - ((b1_pow > OneQ30) ? 64'(OneQ30) : 64'(b1_pow));
    c2 = 64'(OneQ30) - ((b2_pow > OneQ30) ? 64'(OneQ30) : 64'(b2_pow));
    if (c1 == 0) c1 = 64'(OneQ30);
    if (c2 == 0) c2 = 64'(OneQ30);
    mhat = rnd_div(m * longint'(OneQ30), c1);
    sv   = int_sqrt(v << 16);
    sc2  = int_sqrt(c2 << 30);
    if (sc2 == 0) sc2 = 1;
    den  = longint'(rnd_div(longint'(sv << 30), sc2)) + 1;
    stp  = rnd_div(longint'(lr) * mhat, den);
    param_mem[idx] = clamp32(longint'(param_mem[idx]) - stp);
    return param_mem[idx];
  endfunction

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    param_result_t exp_r;
    logic [IdxW-1:0]   got_elem;
    logic [ParamW-1:0] got_param;
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        param_mem[i] = '0;
        mom1_mem[i]  = '0;
        mom2_mem[i]  = '0;
      end
      step_cnt = '0;
      b1_pow   = OneQ30;
      b2_pow   = OneQ30;
      lr       = LrReset;
      fails    = 0;
      pend     = 0;
      expected_params.delete();
    end else begin
      if (cfg_wr_en_i) lr = cfg_wr_data_i;
      if (s_tvalid_i && s_tready_i) begin
        exp_r.elem  = s_tdata_i[9:0];
        exp_r.param = adam_update(s_tuser_i[0], s_tdata_i[9:0], s_tdata_i[41:10],
                                  s_tuser_i[1]);
        expected_params.push_back(exp_r);
      end
      if (m_tvalid_i && m_tready_i) begin
        got_elem  = m_tdata_i[9:0];
        got_param = m_tdata_i[41:10];
        if (expected_params.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result: elem %0d param %h", got_elem, got_param);
        end else begin
          exp_r = expected_params.pop_front();
          if (got_elem !== exp_r.elem || got_param !== exp_r.param) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: elem exp %0d got %0d, param exp %h got %h",
                       exp_r.elem, got_elem, exp_r.param, got_param);
          end
        end
      end
      pend = expected_params.size();
    end
  end

endmodule

// ===== tb/adam_parameter_update_unit_test.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update unit: testbench top
// Directed then random load and gradient requests under several idling
// patterns and learning rates, with one long result stall; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module adam_parameter_update_unit_test;
  import adampu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 4000000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic [LrW-1:0]    cfg_wr_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata;   // element_index[9:0], value[41:10]
  logic [TuserW-1:0] s_axis_tuser;   // action[0], new_step[1]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [TdataW-1:0] m_axis_tdata;   // element_out[9:0], param_value[41:10]

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int cycles;
  bit loaded [StoreDepth];
  int loaded_q [$];

  adam_parameter_update_unit dut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  adam_parameter_update_checker u_checker (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("adam_parameter_update_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = 3000;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One request, held until accepted
  task automatic send_req(logic act, int idx, logic [31:0] val, logic ns);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, idx[IdxW-1:0]};
    s_axis_tuser  <= {ns, act};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ActLoad && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_q.push_back(idx);
    end
  endtask

  // Learning rate write, only with the block drained
  task automatic write_lr(logic [LrW-1:0] rate);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= rate;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(7))
      0:       return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
      1, 2, 3: return 32'($signed($urandom()) >>> $urandom_range(20, 6));
      4:       return $urandom_range(3) - 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_req();
    int idx;
    if (loaded_q.size() == 0 || $urandom_range(99) < 30) begin
      idx = ($urandom_range(99) < 70) ? $urandom_range(31) : $urandom_range(1023);
      send_req(ActLoad, idx, rand_value(), $urandom_range(7) == 0);
    end else begin
      idx = loaded_q[$urandom_range(loaded_q.size() - 1)];
      send_req(ActGrad, idx, rand_value(), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    logic [LrW-1:0] rates [4];
    int idle_s [4];
    int idle_r [4];
    rates  = '{24'hffffff, 24'd0, 24'd1, 24'd16777};
    idle_s = '{0, 47, 0, 31};
    idle_r = '{0, 0, 47, 31};
    rst_ni         = 1'b0;
    cfg_wr_en_i    = 1'b0;
    cfg_wr_data_i  = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, gradient before any step, new-step on load
    send_req(ActLoad, 0, 32'h7fffffff, 1'b0);
    send_req(ActLoad, 1023, 32'h80000000, 1'b1);
    send_req(ActLoad, 512, 32'h0, 1'b0);
    send_req(ActLoad, 341, 32'h01000000, 1'b0);
    send_req(ActGrad, 0, 32'h7fffffff, 1'b0);
    send_req(ActGrad, 1023, 32'h80000000, 1'b1);
    send_req(ActGrad, 512, 32'h0, 1'b0);
    send_req(ActGrad, 341, 32'hffffffff, 1'b1);
    send_req(ActGrad, 341, 32'h00000001, 1'b0);
    send_req(ActGrad, 0, 32'h80000000, 1'b1);
    send_req(ActGrad, 1023, 32'h7fffffff, 1'b0);
    send_req(ActLoad, 682, 32'hffffffff, 1'b1);
    send_req(ActGrad, 682, 32'h55555555, 1'b1);
    send_req(ActGrad, 682, 32'haaaaaaaa, 1'b0);

    // Random phases, each with its own learning rate and idling pattern
    for (int p = 0; p < 4; p++) begin
      write_lr(rates[p]);
      send_idle_pct  = idle_s[p];
      recv_stall_pct = idle_r[p];
      for (int n = 0; n < 445; n++) begin
        if (p == 1 && n == 200) hold_req = 1'b1;
        random_req();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("adam_parameter_update_unit_test OK");
    end else begin
      $display("adam_parameter_update_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/adampu_pkg.sv
hw/rtl/adampu_div.sv
hw/rtl/adampu_sqrt.sv
hw/rtl/adam_parameter_update_unit.sv
tb/adam_parameter_update_checker.sv
tb/adam_parameter_update_unit_test.sv
